>>> sv/ccmp_pkg.sv
// Shared types, constants and handshake structs for the cache mapping comparator.
package ccmp_pkg;

    localparam int MAX_LINES_DEF  = 128;
    localparam int BLOCKS_DEF     = 256;
    localparam int DATA_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_TIME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_TIME  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_TIME = 3'd4;

    localparam logic [7:0]  LINE_COUNT_RST   = 8'd128;
    localparam logic [6:0]  SET_COUNT_RST    = 7'd4;
    localparam logic [15:0] CACHE_TIME_RST   = 16'd1;
    localparam logic [15:0] MEMORY_TIME_RST  = 16'd10;
    localparam logic [15:0] COMPARE_TIME_RST = 16'd1;

    localparam logic [23:0] LAT24_MAX = 24'hFF_FFFF;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_ACCESS = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  block;
        logic [15:0] data;
    } in_beat_t;

    typedef struct packed {
        logic        direct_hit;
        logic [16:0] direct_latency;
        logic        assoc_hit;
        logic [23:0] assoc_latency;
        logic        set_hit;
        logic [23:0] set_latency;
        logic [15:0] direct_hits;
        logic [15:0] assoc_hits;
        logic [15:0] set_hits;
    } out_beat_t;

    typedef enum logic [1:0] {
        DIV_MODL = 2'd0,   // block mod lines
        DIV_MODS = 2'd1,   // block mod sets
        DIV_WAYS = 2'd2    // lines / sets
    } div_op_t;

    typedef struct packed {
        logic    clr_step;
        logic    load_wr;
        logic    acc_start;
        logic    word_cap;
        logic    div_start;
        div_op_t div_op;
        logic    scan_init;
        logic    dir_cmp;
        logic    scan_cmp;
        logic    fill;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> sv/ccmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ccmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/ccmp_ctrl.sv
// Sequencer for clearing, loads and the per-access lookup steps.
module ccmp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_kind,
    output logic                   s_ready,
    input  ccmp_pkg::dp_status_t   sts,
    output ccmp_pkg::dp_cmd_t      cmd
);

    typedef enum logic [12:0] {
        ST_CLEAR = 13'b0000000000001,
        ST_IDLE  = 13'b0000000000010,
        ST_WORD  = 13'b0000000000100,
        ST_WL    = 13'b0000000001000,
        ST_WS    = 13'b0000000010000,
        ST_WW    = 13'b0000000100000,
        ST_BASE  = 13'b0000001000000,
        ST_DRD   = 13'b0000010000000,
        ST_DCMP  = 13'b0000100000000,
        ST_SRD   = 13'b0001000000000,
        ST_SCMP  = 13'b0010000000000,
        ST_FILL  = 13'b0100000000000,
        ST_FIN   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = ccmp_pkg::DIV_MODL;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == ccmp_pkg::KIND_ACCESS) begin
                        cmd.acc_start = 1'b1;
                        state_next    = ST_WORD;
                    end else begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            ST_WORD: begin
                cmd.word_cap  = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_op    = ccmp_pkg::DIV_MODL;
                state_next    = ST_WL;
            end
            ST_WL: begin
                if (sts.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = ccmp_pkg::DIV_MODS;
                    state_next    = ST_WS;
                end
            end
            ST_WS: begin
                if (sts.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = ccmp_pkg::DIV_WAYS;
                    state_next    = ST_WW;
                end
            end
            ST_WW: begin
                if (sts.div_done) begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE: begin
                cmd.scan_init = 1'b1;
                state_next    = ST_DRD;
            end
            ST_DRD: begin
                state_next = ST_DCMP;
            end
            ST_DCMP: begin
                cmd.dir_cmp = 1'b1;
                state_next  = ST_SRD;
            end
            ST_SRD: begin
                state_next = ST_SCMP;
            end
            ST_SCMP: begin
                cmd.scan_cmp = 1'b1;
                state_next   = sts.scan_last ? ST_FILL : ST_SRD;
            end
            ST_FILL: begin
                cmd.fill   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> sv/ccmp_dp.sv
// Datapath: block table, three line stores, divider, scan, counters, result register.
module ccmp_dp #(
    parameter int MAX_LINES  = ccmp_pkg::MAX_LINES_DEF,
    parameter int BLOCKS     = ccmp_pkg::BLOCKS_DEF,
    parameter int DATA_BITS  = ccmp_pkg::DATA_BITS_DEF,
    parameter int COUNT_BITS = ccmp_pkg::COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ccmp_pkg::in_beat_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ccmp_pkg::out_beat_t               m_data,
    input  logic                              cfg_we,
    input  logic [ccmp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ccmp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  ccmp_pkg::dp_cmd_t                 cmd,
    output ccmp_pkg::dp_status_t              sts
);

    localparam int LINE_W = $clog2(MAX_LINES);
    localparam int CNT_W  = $clog2(MAX_LINES + 1);
    localparam int BLK_W  = $clog2(BLOCKS);
    localparam int DV_W   = (BLK_W > CNT_W) ? BLK_W : CNT_W;
    localparam int DC_W   = $clog2(DV_W + 1);
    localparam int CLR_N  = (BLOCKS > MAX_LINES) ? BLOCKS : MAX_LINES;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int PRD_W  = CNT_W + 16;
    localparam int SUM_W  = (PRD_W + 2 > 25) ? PRD_W + 2 : 25;

    // configuration
    logic [7:0]  lc_reg;
    logic [6:0]  sc_reg;
    logic [15:0] ct_reg, mt_reg, cpt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lc_reg  <= ccmp_pkg::LINE_COUNT_RST;
            sc_reg  <= ccmp_pkg::SET_COUNT_RST;
            ct_reg  <= ccmp_pkg::CACHE_TIME_RST;
            mt_reg  <= ccmp_pkg::MEMORY_TIME_RST;
            cpt_reg <= ccmp_pkg::COMPARE_TIME_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                ccmp_pkg::CFG_LINE_COUNT:   lc_reg  <= cfg_wdata[7:0];
                ccmp_pkg::CFG_SET_COUNT:    sc_reg  <= cfg_wdata[6:0];
                ccmp_pkg::CFG_CACHE_TIME:   ct_reg  <= cfg_wdata;
                ccmp_pkg::CFG_MEMORY_TIME:  mt_reg  <= cfg_wdata;
                ccmp_pkg::CFG_COMPARE_TIME: cpt_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective line and set counts
    logic [CNT_W-1:0] lines, sets;

    always_comb begin
        if (lc_reg == '0) begin
            lines = CNT_W'(1);
        end else if (int'(lc_reg) > MAX_LINES) begin
            lines = CNT_W'(MAX_LINES);
        end else begin
            lines = CNT_W'(lc_reg);
        end
        if (sc_reg == '0) begin
            sets = CNT_W'(1);
        end else if (int'(sc_reg) > int'(lines)) begin
            sets = lines;
        end else begin
            sets = CNT_W'(sc_reg);
        end
    end

    // incoming block number wrapped into the table
    logic [7:0]       blk_r;
    logic [BLK_W-1:0] blk_in;

    always_comb begin
        blk_r = s_data.block;
        for (int k = 7; k >= 0; k--) begin
            if ({24'd0, blk_r} >= (BLOCKS << k)) begin
                blk_r = blk_r - 8'(BLOCKS << k);
            end
        end
        blk_in = BLK_W'(blk_r);
    end

    // clearing pass
    logic [CLR_W-1:0] clr_reg;
    logic             clr_blk, clr_line;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + CLR_W'(1);
        end
    end

    assign clr_blk  = cmd.clr_step && (int'(clr_reg) < BLOCKS);
    assign clr_line = cmd.clr_step && (int'(clr_reg) < MAX_LINES);
    assign sts.clr_done = (clr_reg == CLR_W'(CLR_N - 1));

    // access registers
    logic [BLK_W-1:0]     blk_reg;
    logic [DATA_BITS-1:0] word_reg;
    logic [DATA_BITS-1:0] blk_rd, dir_rd, asc_rd, set_rd;

    always_ff @(posedge aclk) begin
        if (cmd.acc_start) begin
            blk_reg <= blk_in;
        end
        if (cmd.word_cap) begin
            word_reg <= blk_rd;
        end
    end

    // divider, one quotient bit per cycle
    logic [DV_W-1:0]  rem_reg, quo_reg;
    logic [CNT_W-1:0] dvs_reg;
    logic [DC_W-1:0]  dcnt_reg;
    logic             dbusy_reg;
    ccmp_pkg::div_op_t dop_reg;
    logic [DV_W:0]    rem_sh;
    logic             div_done;
    logic [LINE_W-1:0] rem_d_reg, set_idx_reg, base_reg;
    logic [CNT_W-1:0]  ways_reg;

    assign rem_sh   = {rem_reg, quo_reg[DV_W-1]};
    assign div_done = dbusy_reg && (dcnt_reg == '0);
    assign sts.div_done = div_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else if (cmd.div_start) begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= DC_W'(DV_W);
        end else if (div_done) begin
            dbusy_reg <= 1'b0;
        end else if (dbusy_reg) begin
            dcnt_reg <= dcnt_reg - DC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dop_reg <= cmd.div_op;
            rem_reg <= '0;
            case (cmd.div_op)
                ccmp_pkg::DIV_MODL: begin
                    quo_reg <= DV_W'(blk_reg);
                    dvs_reg <= lines;
                end
                ccmp_pkg::DIV_MODS: begin
                    quo_reg <= DV_W'(blk_reg);
                    dvs_reg <= sets;
                end
                default: begin
                    quo_reg <= DV_W'(lines);
                    dvs_reg <= sets;
                end
            endcase
        end else if (dbusy_reg && dcnt_reg != '0) begin
            if (rem_sh >= (DV_W + 1)'(dvs_reg)) begin
                rem_reg <= DV_W'(rem_sh - (DV_W + 1)'(dvs_reg));
                quo_reg <= {quo_reg[DV_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[DV_W-1:0];
                quo_reg <= {quo_reg[DV_W-2:0], 1'b0};
            end
        end
        if (div_done) begin
            case (dop_reg)
                ccmp_pkg::DIV_MODL: rem_d_reg   <= LINE_W'(rem_reg);
                ccmp_pkg::DIV_MODS: set_idx_reg <= LINE_W'(rem_reg);
                default:            ways_reg    <= CNT_W'(quo_reg);
            endcase
        end
        if (cmd.scan_init) begin
            base_reg <= LINE_W'(set_idx_reg * ways_reg);
        end
    end

    // lookups
    logic [CNT_W-1:0]  idx_reg;
    logic              d_hit_reg;
    logic              a_found_reg, a_emp_reg, s_found_reg, s_emp_reg;
    logic [LINE_W-1:0] a_pos_reg, a_epos_reg, s_pos_reg, s_epos_reg;

    assign sts.scan_last = (idx_reg == lines - CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (cmd.dir_cmp) begin
            d_hit_reg <= (dir_rd == word_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            a_found_reg <= 1'b0;
            a_emp_reg   <= 1'b0;
            s_found_reg <= 1'b0;
            s_emp_reg   <= 1'b0;
        end else if (cmd.scan_init) begin
            idx_reg     <= '0;
            a_found_reg <= 1'b0;
            a_emp_reg   <= 1'b0;
            s_found_reg <= 1'b0;
            s_emp_reg   <= 1'b0;
        end else if (cmd.scan_cmp) begin
            idx_reg <= idx_reg + CNT_W'(1);
            if (!a_found_reg) begin
                if (asc_rd == word_reg) begin
                    a_found_reg <= 1'b1;
                end else if (asc_rd == '0 && !a_emp_reg) begin
                    a_emp_reg <= 1'b1;
                end
            end
            if (!s_found_reg && idx_reg < ways_reg) begin
                if (set_rd == word_reg) begin
                    s_found_reg <= 1'b1;
                end else if (set_rd == '0 && !s_emp_reg) begin
                    s_emp_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_cmp) begin
            if (!a_found_reg) begin
                if (asc_rd == word_reg) begin
                    a_pos_reg <= idx_reg[LINE_W-1:0];
                end else if (asc_rd == '0 && !a_emp_reg) begin
                    a_epos_reg <= idx_reg[LINE_W-1:0];
                end
            end
            if (!s_found_reg && idx_reg < ways_reg) begin
                if (set_rd == word_reg) begin
                    s_pos_reg <= idx_reg[LINE_W-1:0];
                end else if (set_rd == '0 && !s_emp_reg) begin
                    s_epos_reg <= idx_reg[LINE_W-1:0];
                end
            end
        end
    end

    // memories
    logic              blk_we, dir_we, asc_we, set_we;
    logic [BLK_W-1:0]  blk_wa;
    logic [LINE_W-1:0] dir_wa, asc_wa, set_wa, set_ra;
    logic [DATA_BITS-1:0] blk_wd, line_wd;

    always_comb begin
        blk_we  = clr_blk || cmd.load_wr;
        blk_wa  = cmd.clr_step ? BLK_W'(clr_reg) : blk_in;
        blk_wd  = cmd.clr_step ? '0 : DATA_BITS'(s_data.data);
        line_wd = cmd.clr_step ? '0 : word_reg;
        dir_we  = clr_line || (cmd.dir_cmp && dir_rd != word_reg);
        dir_wa  = cmd.clr_step ? LINE_W'(clr_reg) : rem_d_reg;
        asc_we  = clr_line || (cmd.fill && !a_found_reg);
        asc_wa  = cmd.clr_step ? LINE_W'(clr_reg) : (a_emp_reg ? a_epos_reg : '0);
        set_we  = clr_line || (cmd.fill && !s_found_reg);
        set_wa  = cmd.clr_step ? LINE_W'(clr_reg)
                               : base_reg + (s_emp_reg ? s_epos_reg : '0);
        set_ra  = base_reg + idx_reg[LINE_W-1:0];
    end

    ccmp_ram #(.WIDTH(DATA_BITS), .DEPTH(BLOCKS)) u_blk_ram (
        .clk(aclk), .we(blk_we), .waddr(blk_wa), .wdata(blk_wd),
        .raddr(blk_in), .rdata(blk_rd)
    );

    ccmp_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_LINES)) u_dir_ram (
        .clk(aclk), .we(dir_we), .waddr(dir_wa), .wdata(line_wd),
        .raddr(rem_d_reg), .rdata(dir_rd)
    );

    ccmp_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_LINES)) u_asc_ram (
        .clk(aclk), .we(asc_we), .waddr(asc_wa), .wdata(line_wd),
        .raddr(idx_reg[LINE_W-1:0]), .rdata(asc_rd)
    );

    ccmp_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_LINES)) u_set_ram (
        .clk(aclk), .we(set_we), .waddr(set_wa), .wdata(line_wd),
        .raddr(set_ra), .rdata(set_rd)
    );

    // hit counters and latency products
    logic [COUNT_BITS-1:0] d_hits_reg, a_hits_reg, s_hits_reg;
    logic [PRD_W-1:0]      a_prod_reg, s_prod_reg;
    logic [CNT_W-1:0]      a_mul, s_mul;

    assign a_mul = a_found_reg ? CNT_W'(a_pos_reg) + CNT_W'(1) : lines;
    assign s_mul = s_found_reg ? CNT_W'(s_pos_reg) : ways_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_hits_reg <= '0;
            a_hits_reg <= '0;
            s_hits_reg <= '0;
        end else if (cmd.fill) begin
            if (d_hit_reg && d_hits_reg != '1) begin
                d_hits_reg <= d_hits_reg + COUNT_BITS'(1);
            end
            if (a_found_reg && a_hits_reg != '1) begin
                a_hits_reg <= a_hits_reg + COUNT_BITS'(1);
            end
            if (s_found_reg && s_hits_reg != '1) begin
                s_hits_reg <= s_hits_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fill) begin
            a_prod_reg <= PRD_W'(a_mul * cpt_reg);
            s_prod_reg <= PRD_W'(s_mul * cpt_reg);
        end
    end

    // result register
    logic [SUM_W-1:0]    a_sum, s_sum;
    logic                m_valid_reg;
    ccmp_pkg::out_beat_t m_data_reg, m_data_next;

    always_comb begin
        a_sum = SUM_W'(a_prod_reg) + SUM_W'(ct_reg) + (a_found_reg ? '0 : SUM_W'(mt_reg));
        s_sum = SUM_W'(s_prod_reg) + SUM_W'(ct_reg) + (s_found_reg ? '0 : SUM_W'(mt_reg));
        m_data_next.direct_hit     = d_hit_reg;
        m_data_next.direct_latency = 17'(ct_reg) + (d_hit_reg ? 17'd0 : 17'(mt_reg));
        m_data_next.assoc_hit      = a_found_reg;
        m_data_next.assoc_latency  = (a_sum > SUM_W'(ccmp_pkg::LAT24_MAX))
                                     ? ccmp_pkg::LAT24_MAX : 24'(a_sum);
        m_data_next.set_hit        = s_found_reg;
        m_data_next.set_latency    = (s_sum > SUM_W'(ccmp_pkg::LAT24_MAX))
                                     ? ccmp_pkg::LAT24_MAX : 24'(s_sum);
        m_data_next.direct_hits    = 16'(d_hits_reg);
        m_data_next.assoc_hits     = 16'(a_hits_reg);
        m_data_next.set_hits       = 16'(s_hits_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign sts.out_free = !m_valid_reg || m_ready;

    // checks
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while held");

    a_set_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_cmp |-> (CNT_W + 1)'(base_reg) + (CNT_W + 1)'(ways_reg)
                         <= (CNT_W + 1)'(lines))
        else $error("set range runs past the lines in use");

    a_hits_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (a_hits_reg >= $past(a_hits_reg)))
        else $error("associative hit count went down");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill && a_found_reg |-> (CNT_W'(a_pos_reg) < lines))
        else $error("associative hit beyond lines in use");

endmodule

>>> sv/cache_mapping_comparator.sv
// Top level: compares direct, fully associative and set-associative line stores.
// Load beat: written into the block table in its accept cycle; loads go back to back.
// Access beat: the word is captured; serial divisions of DV_W quotient bits, where
//   DV_W = max(clog2(BLOCKS), clog2(MAX_LINES+1)), give block mod lines, block mod sets
//   and lines/sets; the direct line is compared, the lines in use are scanned (the scan
//   dominates), stores are filled and the result loaded once the result register is free.
// Reset: synchronous; a clearing pass over max(BLOCKS, MAX_LINES) addresses zeroes all
//   stores. s_ready is low throughout the clearing pass and every access.
module cache_mapping_comparator #(
    parameter int MAX_LINES  = ccmp_pkg::MAX_LINES_DEF,
    parameter int BLOCKS     = ccmp_pkg::BLOCKS_DEF,
    parameter int DATA_BITS  = ccmp_pkg::DATA_BITS_DEF,
    parameter int COUNT_BITS = ccmp_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input beats
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ccmp_pkg::in_beat_t               s_data,
    // result beats
    output logic                             m_valid,
    input  logic                             m_ready,
    output ccmp_pkg::out_beat_t              m_data,
    // configuration writes
    input  logic                             cfg_we,
    input  logic [ccmp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccmp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // Controller only steers; all storage and arithmetic live in the datapath.
    ccmp_pkg::dp_cmd_t    cmd;
    ccmp_pkg::dp_status_t sts;

    ccmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath holds the block table, the three line stores, the divider that
    // derives line/set indexes and ways, the scan, hit counters and the result
    // register, which lets a new beat be accepted while a result waits.
    ccmp_dp #(
        .MAX_LINES  (MAX_LINES),
        .BLOCKS     (BLOCKS),
        .DATA_BITS  (DATA_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the cache mapping comparator.
`timescale 1ns / 100ps

module tb;

    // ---------------------------------------------------------------------
    // Clock, reset, block ports
    // ---------------------------------------------------------------------
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    ccmp_pkg::in_beat_t   s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    ccmp_pkg::out_beat_t  m_data;
    logic                 cfg_we = 1'b0;
    logic [ccmp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ccmp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    cache_mapping_comparator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // ---------------------------------------------------------------------
    // Shadow copy of the block's state: block table, three line stores,
    // hit counters and the register file.
    // ---------------------------------------------------------------------
    logic [15:0] tbl_data [256];
    logic [15:0] dir_store [128];
    logic [15:0] asc_store [128];
    logic [15:0] set_store [128];
    logic [15:0] dir_cnt, asc_cnt, set_cnt;
    logic [7:0]  r_lines;
    logic [6:0]  r_sets;
    logic [15:0] r_cache, r_mem, r_cmp;

    ccmp_pkg::out_beat_t access_results_q[$];  // expected result beats, oldest first
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          in_drain = 1'b0;      // low-idle stretch for the receiver
    bit          hold_off = 1'b0;      // long receiver back-pressure window
    bit          quiet_send = 1'b0;    // sender stops idling

    function automatic logic [15:0] bump16(logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function automatic logic [23:0] sat24(longint unsigned v);
        return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
    endfunction

    // Lookup and fill within a range of one store; returns hit, pos is the
    // match index or n on a miss.
    function automatic bit probe_fill(ref logic [15:0] st [128], input int base,
                                      input int n, input logic [15:0] w,
                                      output int pos);
        pos = n;
        for (int i = 0; i < n; i++)
            if (st[base+i] == w) begin
                pos = i;
                return 1'b1;
            end
        for (int i = 0; i < n; i++)
            if (st[base+i] == 16'd0) begin
                st[base+i] = w;
                return 1'b0;
            end
        st[base] = w;
        return 1'b0;
    endfunction

    // Apply one accepted beat to the shadow state; push a result for access.
    task automatic predict_lookup(input ccmp_pkg::in_beat_t b);
        int lines, sets, ways, pos, base;
        longint unsigned lat;
        logic [15:0] w;
        ccmp_pkg::out_beat_t r;
        bit h;
        if (b.kind == ccmp_pkg::KIND_LOAD) begin
            tbl_data[b.block] = b.data;
            return;
        end
        lines = (r_lines == 0) ? 1 : r_lines;
        if (lines > 128) lines = 128;
        sets = (r_sets == 0) ? 1 : r_sets;
        if (sets > lines) sets = lines;
        ways = lines / sets;
        w = tbl_data[b.block];
        r = '0;
        // direct mapped
        pos = b.block % lines;
        h = (dir_store[pos] == w);
        if (h) begin
            dir_cnt = bump16(dir_cnt);
            lat = r_cache;
        end else begin
            dir_store[pos] = w;
            lat = longint'(r_cache) + r_mem;
        end
        r.direct_hit = h;
        r.direct_latency = (lat > 64'h1FFFF) ? 17'h1FFFF : lat[16:0];
        // fully associative
        h = probe_fill(asc_store, 0, lines, w, pos);
        if (h) begin
            asc_cnt = bump16(asc_cnt);
            lat = longint'(pos + 1) * r_cmp + r_cache;
        end else begin
            lat = longint'(lines) * r_cmp + r_cache + r_mem;
        end
        r.assoc_hit = h;
        r.assoc_latency = sat24(lat);
        // set associative
        base = (b.block % sets) * ways;
        h = probe_fill(set_store, base, ways, w, pos);
        if (h) begin
            set_cnt = bump16(set_cnt);
            lat = longint'(pos) * r_cmp + r_cache;
        end else begin
            lat = longint'(ways) * r_cmp + r_cache + r_mem;
        end
        r.set_hit = h;
        r.set_latency = sat24(lat);
        r.direct_hits = dir_cnt;
        r.assoc_hits = asc_cnt;
        r.set_hits = set_cnt;
        access_results_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch @%0d: %s got %0h want %0h", cycle_count, what, got, want);
        fail_count++;
    endtask

    // ---------------------------------------------------------------------
    // Result side: check every accepted result beat against the oldest
    // expectation. m_ready idles at random, except in drain stretches and
    // held low during the back-pressure window.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        ccmp_pkg::out_beat_t e;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (access_results_q.size() == 0) begin
                report_mismatch("unexpected beat", 32'd0, 32'd0);
            end else begin
                e = access_results_q.pop_front();
                if (m_data.direct_hit !== e.direct_hit)
                    report_mismatch("direct_hit", m_data.direct_hit, e.direct_hit);
                if (m_data.direct_latency !== e.direct_latency)
                    report_mismatch("direct_latency", m_data.direct_latency,
                                    e.direct_latency);
                if (m_data.assoc_hit !== e.assoc_hit)
                    report_mismatch("assoc_hit", m_data.assoc_hit, e.assoc_hit);
                if (m_data.assoc_latency !== e.assoc_latency)
                    report_mismatch("assoc_latency", m_data.assoc_latency,
                                    e.assoc_latency);
                if (m_data.set_hit !== e.set_hit)
                    report_mismatch("set_hit", m_data.set_hit, e.set_hit);
                if (m_data.set_latency !== e.set_latency)
                    report_mismatch("set_latency", m_data.set_latency, e.set_latency);
                if (m_data.direct_hits !== e.direct_hits)
                    report_mismatch("direct_hits", m_data.direct_hits, e.direct_hits);
                if (m_data.assoc_hits !== e.assoc_hits)
                    report_mismatch("assoc_hits", m_data.assoc_hits, e.assoc_hits);
                if (m_data.set_hits !== e.set_hits)
                    report_mismatch("set_hits", m_data.set_hits, e.set_hits);
            end
        end
        if (hold_off)
            m_ready <= 1'b0;
        else if (in_drain)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(99) >= 34);
    end

    // Back-pressure window: counted in cycles in its own process.
    initial begin
        int n;
        wait (cycle_count == 40000);
        @(posedge aclk);
        hold_off = 1'b1;
        for (n = 0; n < 6000; n++) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Watchdog. The limit is the worst case per access plus stalls, taken
    // several times over.
    always @(posedge aclk)
        if (cycle_count > 3000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    // Valid stays up after a beat when the next one follows at once.
    task automatic send_beat(input ccmp_pkg::in_beat_t b);
        if (!quiet_send)
            while ($urandom_range(99) < 34) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
        predict_lookup(b);
    endtask

    task automatic write_reg(input logic [ccmp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ccmp_pkg::CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            ccmp_pkg::CFG_LINE_COUNT:   r_lines = v[7:0];
            ccmp_pkg::CFG_SET_COUNT:    r_sets = v[6:0];
            ccmp_pkg::CFG_CACHE_TIME:   r_cache = v;
            ccmp_pkg::CFG_MEMORY_TIME:  r_mem = v;
            ccmp_pkg::CFG_COMPARE_TIME: r_cmp = v;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Drop valid, wait for all results, then cover the access latency tail.
    task automatic settle();
        s_valid <= 1'b0;
        in_drain = 1'b1;
        while (access_results_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        in_drain = 1'b0;
    endtask

    // Directed rows: beat plus an optional typed-in expectation.
    typedef struct {
        ccmp_pkg::in_beat_t  b;
        bit                  fixed;
        ccmp_pkg::out_beat_t want;
    } dir_row_t;

    task automatic run_phase(input int n_items, input int n_blocks);
        ccmp_pkg::in_beat_t b;
        for (int i = 0; i < n_items; i++) begin
            b.block = 8'($urandom_range(n_blocks - 1));
            b.data = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
            // mostly accesses to random blocks; some loads to keep data moving
            b.kind = ($urandom_range(99) < 70) ? ccmp_pkg::KIND_ACCESS
                                               : ccmp_pkg::KIND_LOAD;
            if ($urandom_range(49) == 0) b.block = 8'($urandom);
            send_beat(b);
        end
    endtask

    initial begin
        dir_row_t rows[$];
        dir_row_t r;
        ccmp_pkg::out_beat_t got_hint;
        foreach (tbl_data[i]) tbl_data[i] = '0;
        foreach (dir_store[i]) begin
            dir_store[i] = '0;
            asc_store[i] = '0;
            set_store[i] = '0;
        end
        dir_cnt = '0; asc_cnt = '0; set_cnt = '0;
        r_lines = ccmp_pkg::LINE_COUNT_RST; r_sets = ccmp_pkg::SET_COUNT_RST;
        r_cache = ccmp_pkg::CACHE_TIME_RST; r_mem = ccmp_pkg::MEMORY_TIME_RST;
        r_cmp = ccmp_pkg::COMPARE_TIME_RST;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset settings. First access of an unloaded block
        // reads a zero word, which matches every empty line: hits everywhere.
        r.fixed = 1'b1;
        r.b = '{kind: ccmp_pkg::KIND_ACCESS, block: 8'd0, data: 16'hFFFF};
        r.want = '{direct_hit: 1'b1, direct_latency: 17'd1, assoc_hit: 1'b1,
                   assoc_latency: 24'd2, set_hit: 1'b1, set_latency: 24'd1,
                   direct_hits: 16'd1, assoc_hits: 16'd1, set_hits: 16'd1};
        rows.push_back(r);
        r.fixed = 1'b0;
        r.b = '{kind: ccmp_pkg::KIND_LOAD, block: 8'd255, data: 16'hFFFF};
        rows.push_back(r);
        r.b = '{kind: ccmp_pkg::KIND_ACCESS, block: 8'd255, data: 16'h0000};
        rows.push_back(r);
        r.b = '{kind: ccmp_pkg::KIND_ACCESS, block: 8'd255, data: 16'h1234};
        rows.push_back(r);
        r.b = '{kind: ccmp_pkg::KIND_LOAD, block: 8'd127, data: 16'h0001};
        rows.push_back(r);
        r.b = '{kind: ccmp_pkg::KIND_ACCESS, block: 8'd127, data: 16'h0};
        rows.push_back(r);
        r.b = '{kind: ccmp_pkg::KIND_LOAD, block: 8'd128, data: 16'h8000};
        rows.push_back(r);
        r.b = '{kind: ccmp_pkg::KIND_ACCESS, block: 8'd128, data: 16'h0};
        rows.push_back(r);
        r.b = '{kind: ccmp_pkg::KIND_ACCESS, block: 8'd0, data: 16'h0};
        rows.push_back(r);
        r.b = '{kind: ccmp_pkg::KIND_LOAD, block: 8'd128, data: 16'h0};
        rows.push_back(r);
        r.b = '{kind: ccmp_pkg::KIND_ACCESS, block: 8'd128, data: 16'h0};
        rows.push_back(r);
        foreach (rows[i]) begin
            send_beat(rows[i].b);
            if (rows[i].fixed) begin
                got_hint = access_results_q[access_results_q.size()-1];
                if (got_hint !== rows[i].want)
                    report_mismatch("directed row", i, 0);
                access_results_q[access_results_q.size()-1] = rows[i].want;
            end
        end
        settle();

        // Minimum sizes, zero times: every line shared, latency terms vanish.
        write_reg(ccmp_pkg::CFG_LINE_COUNT, 16'd1);
        write_reg(ccmp_pkg::CFG_SET_COUNT, 16'd1);
        write_reg(ccmp_pkg::CFG_CACHE_TIME, 16'd0);
        write_reg(ccmp_pkg::CFG_MEMORY_TIME, 16'd0);
        write_reg(ccmp_pkg::CFG_COMPARE_TIME, 16'd0);
        run_phase(120, 8);
        settle();

        // Out-of-range sizes: zero counts and lines above the store; full bit patterns.
        write_reg(ccmp_pkg::CFG_LINE_COUNT, 16'd0);
        write_reg(ccmp_pkg::CFG_SET_COUNT, 16'd0);
        run_phase(30, 4);
        settle();
        write_reg(ccmp_pkg::CFG_LINE_COUNT, 16'hFFFF);
        write_reg(ccmp_pkg::CFG_SET_COUNT, 16'h007F);
        write_reg(ccmp_pkg::CFG_CACHE_TIME, 16'hFFFF);
        write_reg(ccmp_pkg::CFG_MEMORY_TIME, 16'hFFFF);
        write_reg(ccmp_pkg::CFG_COMPARE_TIME, 16'hFFFF);
        run_phase(120, 256);
        settle();

        // Sets not dividing lines, small store to force evictions; the
        // back-pressure window falls somewhere in here.
        write_reg(ccmp_pkg::CFG_LINE_COUNT, 16'd12);
        write_reg(ccmp_pkg::CFG_SET_COUNT, 16'd8);
        write_reg(ccmp_pkg::CFG_CACHE_TIME, 16'd3);
        write_reg(ccmp_pkg::CFG_MEMORY_TIME, 16'd100);
        write_reg(ccmp_pkg::CFG_COMPARE_TIME, 16'd2);
        run_phase(300, 40);
        settle();

        // Mid sizes with a quiet sender stretch.
        write_reg(ccmp_pkg::CFG_LINE_COUNT, 16'd64);
        write_reg(ccmp_pkg::CFG_SET_COUNT, 16'd64);
        quiet_send = 1'b1;
        run_phase(200, 100);
        quiet_send = 1'b0;
        settle();

        // Back to reset values for the tail.
        write_reg(ccmp_pkg::CFG_LINE_COUNT, 16'd128);
        write_reg(ccmp_pkg::CFG_SET_COUNT, 16'd4);
        write_reg(ccmp_pkg::CFG_CACHE_TIME, 16'd1);
        write_reg(ccmp_pkg::CFG_MEMORY_TIME, 16'd10);
        write_reg(ccmp_pkg::CFG_COMPARE_TIME, 16'd1);
        run_phase(420, 256);
        settle();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
